// ----- sv/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character mapping for the
// streaming base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int CARRY_W = 4;
    localparam int SEXT_W  = 6;

    // characters per queue entry and index width
    localparam int MAX_CHARS = 4;
    localparam int IDX_W     = $clog2(MAX_CHARS);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // '=' padding character
    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

    // position within the current three-byte group
    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    // one queue entry: the characters one byte produces
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             eom;
    } t_entry;

    // queue status seen by the front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXT_W-1:0] v);
        logic [CHAR_W-1:0] ch;
        if (v < 6'd26) begin
            ch = 7'd65 + 7'(v);
        end else if (v < 6'd52) begin
            ch = 7'd97 + 7'(v - 6'd26);
        end else if (v < 6'd62) begin
            ch = 7'd48 + 7'(v - 6'd52);
        end else if (v == 6'd62) begin
            ch = 7'd43;
        end else begin
            ch = 7'd47;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/b64e_front.sv -----
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks the group phase and leftover bits, and builds
// one queue entry holding the characters each byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [b64e_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_end_of_message,
    input  wire b64e_pkg::t_q_status           i_q_status,
    output logic                               o_push,
    output b64e_pkg::t_entry                   o_entry
);

    logic [b64e_pkg::CARRY_W-1:0] r_carry;
    logic [b64e_pkg::CARRY_W-1:0] n_carry;
    logic [1:0]                   r_phase;
    logic [1:0]                   n_phase;
    logic                         w_accept;

    assign w_accept = i_valid && !i_q_status.full;
    assign o_push   = w_accept;

    // classify the byte and build its characters
    always_comb begin
        o_entry          = '0;
        n_carry          = r_carry;
        n_phase          = r_phase;
        o_entry.eom      = i_end_of_message;
        case (r_phase)
            b64e_pkg::PHASE_ONE: begin
                o_entry.chars[0] = b64e_pkg::sextet_char({r_carry[1:0], i_data_byte[7:4]});
                o_entry.last_idx = 2'd0;
                n_carry          = i_data_byte[3:0];
                n_phase          = b64e_pkg::PHASE_TWO;
            end
            b64e_pkg::PHASE_TWO: begin
                o_entry.chars[0] = b64e_pkg::sextet_char({r_carry, i_data_byte[7:6]});
                o_entry.chars[1] = b64e_pkg::sextet_char(i_data_byte[5:0]);
                o_entry.last_idx = 2'd1;
                n_carry          = '0;
                n_phase          = b64e_pkg::PHASE_START;
            end
            default: begin
                o_entry.chars[0] = b64e_pkg::sextet_char(i_data_byte[7:2]);
                o_entry.last_idx = 2'd0;
                n_carry          = {2'b00, i_data_byte[1:0]};
                n_phase          = b64e_pkg::PHASE_ONE;
            end
        endcase

        // message end: flush leftover bits and pad
        if (i_end_of_message) begin
            case (n_phase)
                b64e_pkg::PHASE_ONE: begin
                    o_entry.chars[1] = b64e_pkg::sextet_char({n_carry[1:0], 4'b0000});
                    o_entry.chars[2] = b64e_pkg::PAD_CHAR;
                    o_entry.chars[3] = b64e_pkg::PAD_CHAR;
                    o_entry.last_idx = 2'd3;
                end
                b64e_pkg::PHASE_TWO: begin
                    o_entry.chars[1] = b64e_pkg::sextet_char({n_carry, 2'b00});
                    o_entry.chars[2] = b64e_pkg::PAD_CHAR;
                    o_entry.last_idx = 2'd2;
                end
                default: begin
                end
            endcase
            n_carry = '0;
            n_phase = b64e_pkg::PHASE_START;
        end
    end

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_phase <= b64e_pkg::PHASE_START;
        end else if (w_accept) begin
            r_carry <= n_carry;
            r_phase <= n_phase;
        end
    end

    // phase code three is never reached
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("group phase out of range");

    // a message end restarts the group
    a_eom_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_end_of_message) |=>
            (r_phase == b64e_pkg::PHASE_START && r_carry == '0))
        else $error("group not restarted after message end");

endmodule

`default_nettype wire

// ----- sv/b64e_queue.sv -----
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of character entries between the front
// and the back, with the head entry visible before it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire b64e_pkg::t_entry     i_entry,
    input  wire logic                 i_pop,
    output b64e_pkg::t_q_status       o_status,
    output b64e_pkg::t_entry          o_head
);

    b64e_pkg::t_entry                 r_mem [b64e_pkg::Q_DEPTH];
    logic [b64e_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [b64e_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [b64e_pkg::Q_CNT_W-1:0]     r_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == b64e_pkg::Q_CNT_W'(b64e_pkg::Q_DEPTH));
    assign o_head         = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // fill count stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= b64e_pkg::Q_CNT_W'(b64e_pkg::Q_DEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ----- sv/b64e_back.sv -----
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head queue entry's characters one per cycle, unless stalled, into the
// output register, flagging the final character of a message.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire b64e_pkg::t_q_status           i_q_status,
    input  wire b64e_pkg::t_entry              i_head,
    output logic                               o_pop,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [b64e_pkg::CHAR_W-1:0]        o_out_char,
    output logic                               o_last_char
);

    logic [b64e_pkg::IDX_W-1:0]  r_idx;
    logic                        r_valid;
    logic [b64e_pkg::CHAR_W-1:0] r_char;
    logic                        r_last;
    logic                        w_load;
    logic                        w_take;
    logic                        w_at_end;

    // output register may take a new word
    assign w_load   = !r_valid || !i_stall;
    assign w_take   = w_load && !i_q_status.empty;
    assign w_at_end = (r_idx == i_head.last_idx);
    assign o_pop    = w_take && w_at_end;

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

    // character index within the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_take) begin
            r_idx <= w_at_end ? '0 : r_idx + 1'b1;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_q_status.empty;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_char <= i_head.chars[r_idx];
            r_last <= i_head.eom && w_at_end;
        end
    end

    // index never runs past the entry
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.empty |-> (r_idx <= i_head.last_idx))
        else $error("character index past end of entry");

endmodule

`default_nettype wire

// ----- sv/base64_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// path: a byte's first character goes through the queue entry and the output register
// throughput: one character per cycle out of the back end while the output is not
//   stalled, a byte giving one to four characters (its character count: 1, 1, 2 per
//   group, up to 4 at message end); the input keeps flowing while the two-entry queue has room
// reset: synchronous active low, clears group phase, leftover bits, queue
//   and output valid; no clearing pass
`default_nettype none

module base64_stream_encoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [b64e_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_end_of_message,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [b64e_pkg::CHAR_W-1:0]        o_out_char,
    output logic                               o_last_char
);

    b64e_pkg::t_q_status w_q_status;
    b64e_pkg::t_entry    w_push_entry;
    b64e_pkg::t_entry    w_head;
    logic                w_push;
    logic                w_pop;

    assign o_in_stall = w_q_status.full;

    // byte intake and classification
    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_q_status       (w_q_status),
        .o_push           (w_push),
        .o_entry          (w_push_entry)
    );

    // decoupling queue
    b64e_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_head   (w_head)
    );

    // character emission
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire
